>>> hw/rtl/trp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_pkg
// shared types, register indexes, status codes and option text for the
// request parser
// ----------------------------------------------------------------------------
package trp_pkg;

    // default limits for the filename and mode strings
    localparam int NAME_MAX_LEN_DEF = 256;
    localparam int MODE_MAX_LEN_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_FALLBACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLKSIZE_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLKSIZE_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLKSIZE_FALLBACK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TSIZE_HIGH       = 3'd6;

    localparam logic [7:0]  TIMEOUT_LOW_RST      = 8'd1;
    localparam logic [7:0]  TIMEOUT_HIGH_RST     = 8'd255;
    localparam logic [7:0]  TIMEOUT_FALLBACK_RST = 8'd5;
    localparam logic [15:0] BLKSIZE_LOW_RST      = 16'd8;
    localparam logic [15:0] BLKSIZE_HIGH_RST     = 16'd65464;
    localparam logic [15:0] BLKSIZE_FALLBACK_RST = 16'd512;
    localparam logic [31:0] TSIZE_HIGH_RST       = 32'd1;

    // result status
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_BAD_OPCODE = 3'd2;
    localparam logic [2:0] ST_BAD_NAME   = 3'd3;
    localparam logic [2:0] ST_BAD_MODE   = 3'd4;
    localparam logic [2:0] ST_BAD_OPTION = 3'd5;

    // request opcodes
    localparam logic [15:0] OPC_RRQ = 16'd1;
    localparam logic [15:0] OPC_WRQ = 16'd2;
    localparam logic [15:0] OPC_SHORT = 16'hFFFF;

    // shortest packet that is not reported as too short
    localparam logic [2:0] MIN_PKT_LEN = 3'd6;

    // option-name length saturates here
    localparam logic [8:0] TOK_SAT = 9'd511;
    // an unfinished option name this long or longer is reported
    localparam logic [8:0] OPT_TAIL_MIN = 9'd3;

    // option selectors
    localparam logic [1:0] OPT_TIMEOUT = 2'd0;
    localparam logic [1:0] OPT_BLKSIZE = 2'd1;
    localparam logic [1:0] OPT_TSIZE   = 2'd2;
    localparam logic [1:0] OPT_NONE    = 2'd3;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic [7:0]  timeout_low;
        logic [7:0]  timeout_high;
        logic [7:0]  timeout_fallback;
        logic [15:0] blksize_low;
        logic [15:0] blksize_high;
        logic [15:0] blksize_fallback;
        logic [31:0] tsize_high;
    } cfg_t;

    // commands from the byte parser to the option value unit
    typedef struct packed {
        logic       clear;     // packet done, drop everything
        logic       start;     // a value begins
        logic       digit_en;  // a value byte arrives
        logic       apply;     // value terminated, record it
        logic [1:0] sel;       // option that the value belongs to
        logic [7:0] data;      // the byte itself
    } opt_ctrl_t;

    typedef struct packed {
        logic        has_timeout;
        logic [7:0]  timeout_value;
        logic        has_blksize;
        logic [15:0] blksize_value;
        logic        has_tsize;
        logic [31:0] tsize_value;
    } opt_res_t;

    // result word, last field (status) in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] tsize_value;
        logic        has_tsize;
        logic [15:0] blksize_value;
        logic        has_blksize;
        logic [7:0]  timeout_value;
        logic        has_timeout;
        logic [4:0]  mode_length;
        logic [8:0]  name_length;
        logic [15:0] req_opcode;
        logic [2:0]  status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [2:0] opt_len(input logic [1:0] sel);
        logic [2:0] len;
        begin
            unique case (sel)
                OPT_TIMEOUT: len = 3'd7;
                OPT_BLKSIZE: len = 3'd7;
                OPT_TSIZE:   len = 3'd5;
                default:     len = 3'd0;
            endcase
            return len;
        end
    endfunction

    // character of an option name at a position, names left aligned
    function automatic logic [7:0] opt_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [55:0] txt;
        logic [2:0]  idx;
        begin
            unique case (sel)
                OPT_TIMEOUT: txt = "timeout";
                OPT_BLKSIZE: txt = "blksize";
                OPT_TSIZE:   txt = {"tsize", 16'h0000};
                default:     txt = '0;
            endcase
            idx = 3'd6 - pos;
            if (pos == 3'd7) begin
                return CHAR_NUL;
            end
            return txt[{idx, 3'b000} +: 8];
        end
    endfunction

endpackage

>>> hw/rtl/trp_opt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_opt_unit
// decimal value accumulator and range check for the recognised options
// ----------------------------------------------------------------------------
module trp_opt_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  trp_pkg::cfg_t      cfg,
    input  trp_pkg::opt_ctrl_t ctrl,
    output trp_pkg::opt_res_t  res_next
);
    import trp_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic        bad_reg, bad_next;
    logic        empty_reg, empty_next;
    opt_res_t    res_reg;
    opt_res_t    res_calc;

    logic [35:0] acc_x10;
    logic [35:0] acc_sum;
    logic        is_digit;
    logic        ok;

    // value * 10 + digit, saturating at 32 bits
    assign acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign acc_sum  = acc_x10 + {32'd0, ctrl.data[3:0] - CHAR_ZERO[3:0]};
    assign is_digit = (ctrl.data >= CHAR_ZERO) && (ctrl.data <= CHAR_NINE);
    assign ok       = !bad_reg && !empty_reg;

    always_comb begin
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        empty_next = empty_reg;
        res_calc   = res_reg;
        if (ctrl.start) begin
            acc_next   = '0;
            bad_next   = 1'b0;
            empty_next = 1'b1;
        end
        if (ctrl.digit_en) begin
            empty_next = 1'b0;
            if (is_digit) begin
                acc_next = (acc_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_sum[31:0];
            end else begin
                bad_next = 1'b1;
            end
        end
        if (ctrl.apply) begin
            unique case (ctrl.sel)
                OPT_TIMEOUT: begin
                    res_calc.has_timeout = 1'b1;
                    res_calc.timeout_value =
                        (ok && acc_reg >= {24'd0, cfg.timeout_low}
                            && acc_reg <= {24'd0, cfg.timeout_high})
                        ? acc_reg[7:0] : cfg.timeout_fallback;
                end
                OPT_BLKSIZE: begin
                    res_calc.has_blksize = 1'b1;
                    res_calc.blksize_value =
                        (ok && acc_reg >= {16'd0, cfg.blksize_low}
                            && acc_reg <= {16'd0, cfg.blksize_high})
                        ? acc_reg[15:0] : cfg.blksize_fallback;
                end
                OPT_TSIZE: begin
                    res_calc.has_tsize = 1'b1;
                    res_calc.tsize_value = (ok && acc_reg <= cfg.tsize_high) ? acc_reg : 32'd0;
                end
                default: begin
                end
            endcase
        end
    end

    assign res_next = res_calc;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            acc_reg   <= '0;
            bad_reg   <= 1'b0;
            empty_reg <= 1'b1;
            res_reg   <= '0;
        end else begin
            acc_reg   <= acc_next;
            bad_reg   <= bad_next;
            empty_reg <= empty_next;
            res_reg   <= res_calc;
        end
    end

    // an empty value has accumulated nothing
    a_empty_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (acc_reg == 32'd0 && !bad_reg))
        else $error("empty value with nonzero accumulator");

    // a started value is empty in the next cycle; a clear also leaves it empty
    a_start_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.start && !ctrl.digit_en) |=> empty_reg)
        else $error("value start did not empty the accumulator");

endmodule

>>> hw/rtl/tftp_request_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_request_parser
// byte-serial parser for read/write requests with timeout, blksize and
// tsize options; one result word per packet
// ----------------------------------------------------------------------------
//
//  channel   dir  width  content
//  s_*       in   8+1    packet byte in tdata, final byte flagged by tlast
//  m_*       out  96     one result per packet, issued on its final byte
//  cfg_*     in   3+32   range and fallback register writes
//
//  one byte is taken every clock while the skid register is empty; the parser
//  state is updated in the same cycle as the transfer by a single pass of byte
//  logic; the result of the final byte is registered in the output register,
//  or in the skid register while the output waits, so the skid holds a second
//  result and s_tready only falls while two results wait downstream
//  reset is synchronous and active low; no memory, no clearing pass
//
module tftp_request_parser #(
    parameter int NAME_MAX_LEN = trp_pkg::NAME_MAX_LEN_DEF,
    parameter int MODE_MAX_LEN = trp_pkg::MODE_MAX_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // pkt_byte
    input  logic                           s_tlast,   // pkt_last
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, req_opcode, name_length, mode_length, has_timeout,
    // timeout_value, has_blksize, blksize_value, has_tsize, tsize_value, pad
    output logic [trp_pkg::RESULT_W-1:0]   m_tdata,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [trp_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [trp_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import trp_pkg::*;

    // token counter covers the name limit and the option-name saturation
    localparam int NAME_W = $clog2(NAME_MAX_LEN + 1);
    localparam int TOK_W  = (NAME_W > 9) ? NAME_W : 9;
    localparam logic [TOK_W-1:0] NAME_LIM = TOK_W'(NAME_MAX_LEN);
    localparam logic [TOK_W-1:0] MODE_LIM = TOK_W'(MODE_MAX_LEN);
    localparam logic [TOK_W-1:0] TOK_MAX  = TOK_W'(TOK_SAT);
    localparam logic [TOK_W-1:0] TAIL_MIN = TOK_W'(OPT_TAIL_MIN);

    // parse phases
    localparam logic [2:0] PH_OPC  = 3'd0;
    localparam logic [2:0] PH_NAME = 3'd1;
    localparam logic [2:0] PH_MODE = 3'd2;
    localparam logic [2:0] PH_OPTN = 3'd3;
    localparam logic [2:0] PH_OPTV = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;
    localparam logic [2:0] PH_HALT = 3'd6;

    // configuration registers
    cfg_t cfg_reg;

    // parser state
    logic [2:0]       phase_reg, phase_next;
    logic [2:0]       count_reg, count_next;      // bytes seen, saturates at six
    logic [15:0]      opcode_reg, opcode_next;
    logic [TOK_W-1:0] token_reg, token_next;
    logic [2:0]       flags_reg, flags_next;      // option names still matching
    logic [1:0]       cur_opt_reg, cur_opt_next;
    logic [2:0]       err_reg, err_next;
    logic [8:0]       name_len_reg, name_len_next;
    logic [4:0]       mode_len_reg, mode_len_next;

    // output register and skid stage
    logic    m_valid_reg;
    result_t m_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    logic      s_xfer;
    logic      pkt_done;
    logic      m_free;
    opt_ctrl_t ctrl;
    opt_res_t  opt_res;
    logic [2:0] status;
    result_t   result;

    assign s_tready = !skid_valid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign pkt_done = s_xfer && s_tlast;
    assign m_free   = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_low      <= TIMEOUT_LOW_RST;
            cfg_reg.timeout_high     <= TIMEOUT_HIGH_RST;
            cfg_reg.timeout_fallback <= TIMEOUT_FALLBACK_RST;
            cfg_reg.blksize_low      <= BLKSIZE_LOW_RST;
            cfg_reg.blksize_high     <= BLKSIZE_HIGH_RST;
            cfg_reg.blksize_fallback <= BLKSIZE_FALLBACK_RST;
            cfg_reg.tsize_high       <= TSIZE_HIGH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TIMEOUT_LOW:      cfg_reg.timeout_low      <= cfg_wr_data[7:0];
                REG_TIMEOUT_HIGH:     cfg_reg.timeout_high     <= cfg_wr_data[7:0];
                REG_TIMEOUT_FALLBACK: cfg_reg.timeout_fallback <= cfg_wr_data[7:0];
                REG_BLKSIZE_LOW:      cfg_reg.blksize_low      <= cfg_wr_data[15:0];
                REG_BLKSIZE_HIGH:     cfg_reg.blksize_high     <= cfg_wr_data[15:0];
                REG_BLKSIZE_FALLBACK: cfg_reg.blksize_fallback <= cfg_wr_data[15:0];
                REG_TSIZE_HIGH:       cfg_reg.tsize_high       <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------ byte logic
    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        opcode_next   = opcode_reg;
        token_next    = token_reg;
        flags_next    = flags_reg;
        cur_opt_next  = cur_opt_reg;
        err_next      = err_reg;
        name_len_next = name_len_reg;
        mode_len_next = mode_len_reg;
        ctrl          = '0;
        ctrl.data     = s_tdata;
        ctrl.sel      = cur_opt_reg;
        ctrl.clear    = pkt_done;
        if (s_xfer) begin
            unique case (phase_reg)
                PH_OPC: begin
                    if (count_reg == 3'd0) begin
                        opcode_next = {s_tdata, 8'h00};
                    end else begin
                        opcode_next = {opcode_reg[15:8], s_tdata};
                        if (opcode_next != OPC_RRQ && opcode_next != OPC_WRQ) begin
                            err_next   = ST_BAD_OPCODE;
                            phase_next = PH_HALT;
                        end else begin
                            phase_next = PH_NAME;
                            token_next = '0;
                        end
                    end
                end
                PH_NAME, PH_MODE: begin
                    if (s_tdata == CHAR_NUL) begin
                        if (phase_reg == PH_NAME) begin
                            name_len_next = token_reg[8:0];
                            phase_next    = PH_MODE;
                        end else begin
                            mode_len_next = token_reg[4:0];
                            phase_next    = PH_OPTN;
                            flags_next    = 3'b111;
                        end
                        token_next = '0;
                    end else begin
                        token_next = token_reg + 1'b1;
                        if (phase_reg == PH_NAME && token_next >= NAME_LIM) begin
                            err_next   = ST_BAD_NAME;
                            phase_next = PH_HALT;
                        end else if (phase_reg == PH_MODE && token_next >= MODE_LIM) begin
                            err_next   = ST_BAD_MODE;
                            phase_next = PH_HALT;
                        end
                    end
                end
                PH_OPTN: begin
                    if (s_tdata == CHAR_NUL) begin
                        // first live name whose length matches wins
                        if (flags_reg[0] && token_reg == TOK_W'(opt_len(OPT_TIMEOUT))) begin
                            cur_opt_next = OPT_TIMEOUT;
                        end else if (flags_reg[1]
                                     && token_reg == TOK_W'(opt_len(OPT_BLKSIZE))) begin
                            cur_opt_next = OPT_BLKSIZE;
                        end else if (flags_reg[2]
                                     && token_reg == TOK_W'(opt_len(OPT_TSIZE))) begin
                            cur_opt_next = OPT_TSIZE;
                        end else begin
                            cur_opt_next = OPT_NONE;
                        end
                        phase_next = (cur_opt_next == OPT_NONE) ? PH_SKIP : PH_OPTV;
                        token_next = '0;
                        ctrl.start = 1'b1;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (token_reg >= TOK_W'(opt_len(2'(i)))
                                || opt_char(2'(i), token_reg[2:0]) != s_tdata) begin
                                flags_next[i] = 1'b0;
                            end
                        end
                        if (token_reg < TOK_MAX) begin
                            token_next = token_reg + 1'b1;
                        end
                    end
                end
                PH_OPTV: begin
                    if (s_tdata == CHAR_NUL) begin
                        ctrl.apply = 1'b1;
                        phase_next = PH_OPTN;
                        token_next = '0;
                        flags_next = 3'b111;
                    end else begin
                        ctrl.digit_en = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (s_tdata == CHAR_NUL) begin
                        phase_next = PH_OPTN;
                        token_next = '0;
                        flags_next = 3'b111;
                    end
                end
                default: begin
                    // halted after an error: bytes are dropped
                end
            endcase
            if (count_reg != MIN_PKT_LEN) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // option values live in their own unit
    trp_opt_unit u_opt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .ctrl     (ctrl),
        .res_next (opt_res)
    );

    // ---------------------------------------------------------------- result
    always_comb begin
        priority if (count_next < MIN_PKT_LEN) begin
            status = ST_TOO_SHORT;
        end else if (err_next != ST_OK) begin
            status = err_next;
        end else if (phase_next == PH_NAME) begin
            status = ST_BAD_NAME;
        end else if (phase_next == PH_MODE) begin
            status = ST_BAD_MODE;
        end else if (phase_next == PH_OPTN && token_next >= TAIL_MIN) begin
            status = ST_BAD_OPTION;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        result        = '0;
        result.status = status;
        if (status == ST_TOO_SHORT) begin
            result.req_opcode = OPC_SHORT;
        end else begin
            result.req_opcode = opcode_next;
        end
        if (status == ST_OK) begin
            result.name_length   = name_len_next;
            result.mode_length   = mode_len_next;
            result.has_timeout   = opt_res.has_timeout;
            result.timeout_value = opt_res.has_timeout ? opt_res.timeout_value : 8'd0;
            result.has_blksize   = opt_res.has_blksize;
            // an absent block size reports the fallback
            result.blksize_value = opt_res.has_blksize ? opt_res.blksize_value
                                                       : cfg_reg.blksize_fallback;
            result.has_tsize     = opt_res.has_tsize;
            result.tsize_value   = opt_res.has_tsize ? opt_res.tsize_value : 32'd0;
        end
    end

    // ------------------------------------------------------------ state regs
    always_ff @(posedge aclk) begin
        if (!aresetn || pkt_done) begin
            phase_reg    <= PH_OPC;
            count_reg    <= '0;
            opcode_reg   <= '0;
            token_reg    <= '0;
            flags_reg    <= 3'b111;
            cur_opt_reg  <= OPT_NONE;
            err_reg      <= ST_OK;
            name_len_reg <= '0;
            mode_len_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            opcode_reg   <= opcode_next;
            token_reg    <= token_next;
            flags_reg    <= flags_next;
            cur_opt_reg  <= cur_opt_next;
            err_reg      <= err_next;
            name_len_reg <= name_len_next;
            mode_len_reg <= mode_len_next;
        end
    end

    // ------------------------------------------------- output and skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_free) begin
            if (skid_valid_reg) begin
                // input is stalled while the skid is full, so no new result
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= pkt_done;
            end
        end else if (pkt_done) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_free) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (pkt_done) begin
                m_data_reg <= result;
            end
        end else if (pkt_done) begin
            skid_data_reg <= result;
        end
    end

    // ------------------------------------------------------------ assertions
    a_skid_needs_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_done_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_done |=> m_tvalid)
        else $error("final byte transfer produced no result");

    a_done_rewinds : assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_done |=> (phase_reg == PH_OPC && count_reg == 3'd0 && err_reg == ST_OK))
        else $error("parser not rewound after the final byte");

    a_halt_has_error : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HALT) |-> (err_reg != ST_OK))
        else $error("halted without an error code");

    a_mode_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_MODE) |-> (token_reg < MODE_LIM))
        else $error("mode length passed its limit without an error");

endmodule
